// ===== rtl/tzgp_pkg.sv =====
// ----------------------------------------------------------------------------
// tzgp_pkg
// Shared widths and register indexes for the three-zone gradient pixel block.
// ----------------------------------------------------------------------------
package tzgp_pkg;

  // Payload widths
  localparam int IDX_W   = 7;
  localparam int CHAN_W  = 8;
  localparam int COLOR_W = 3 * CHAN_W;

  // Configuration register indexes
  localparam int REG_IDX_W = 2;
  localparam logic [REG_IDX_W-1:0] REG_FIRST_COLOR  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_SECOND_COLOR = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_THIRD_COLOR  = 2'd2;

endpackage

// ===== rtl/three_zone_gradient_pixel.sv =====
// ----------------------------------------------------------------------------
// three_zone_gradient_pixel
// RGB color of one LED on a strip split in three zones, with linear fades
// across both zone boundaries.
// ----------------------------------------------------------------------------
// Returns the color of each accepted pixel index: the index is captured in an
// input register, the zone and fade window are found and the fade step is
// computed in one pass (one 8 x 17 bit multiply per channel with a constant
// reciprocal), and the color lands in the result register. A new word can
// enter every cycle while in_stall is low; the result and input registers
// stall together only while the output side is stalled and both hold a word.
// The three colors are to be written through the register port while the
// block is idle (not enforced here). An index >= PIXEL_COUNT returns black.
// ----------------------------------------------------------------------------
module three_zone_gradient_pixel #(
  parameter int PIXEL_COUNT = 90,
  parameter int FADE_LENGTH = 15
) (
  input  logic                               clk,
  input  logic                               rst,
  // configuration
  input  logic                               write_enable,
  input  logic [tzgp_pkg::REG_IDX_W-1:0]     write_index,
  input  logic [tzgp_pkg::COLOR_W-1:0]       write_data,
  // input channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [tzgp_pkg::IDX_W-1:0]         pixel_index,
  // output channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [tzgp_pkg::CHAN_W-1:0]        red,
  output logic [tzgp_pkg::CHAN_W-1:0]        green,
  output logic [tzgp_pkg::CHAN_W-1:0]        blue
);

  // Strip geometry
  localparam int M1    = PIXEL_COUNT / 3;
  localparam int M2    = 2 * M1;
  localparam int OFF   = (FADE_LENGTH / 2) % PIXEL_COUNT;
  localparam int BASE1 = (M1 % PIXEL_COUNT + PIXEL_COUNT - OFF) % PIXEL_COUNT;
  localparam int BASE2 = (M2 % PIXEL_COUNT + PIXEL_COUNT - OFF) % PIXEL_COUNT;
  localparam int PW    = ($clog2(PIXEL_COUNT + 1) > tzgp_pkg::IDX_W) ?
                         $clog2(PIXEL_COUNT + 1) : tzgp_pkg::IDX_W;

  // Fade step arithmetic: floor(x / L) = (x * MAGIC) >> SH for x < 2**(8+SW)
  localparam int SW    = $clog2(FADE_LENGTH);
  localparam int STEPS = 2 ** SW;
  localparam int SH    = tzgp_pkg::CHAN_W + 2 * SW;
  localparam int MAGIC = (2 ** SH + FADE_LENGTH - 1) / FADE_LENGTH;
  localparam int KW    = SH + 1;
  localparam int PRW   = SH + tzgp_pkg::CHAN_W + 2;
  localparam int CEIL_ADD = (FADE_LENGTH - 1) * MAGIC;

  // Configuration registers
  logic [tzgp_pkg::COLOR_W-1:0] first_color;
  logic [tzgp_pkg::COLOR_W-1:0] second_color;
  logic [tzgp_pkg::COLOR_W-1:0] third_color;

  // Input register
  logic                         s1_valid;
  logic [tzgp_pkg::IDX_W-1:0]   pix_r;

  // Pipeline control
  logic advance;
  logic accept;

  // Window match and step selection
  logic [FADE_LENGTH-1:0] hit1;
  logic [FADE_LENGTH-1:0] hit2;
  logic [KW-1:0]          k_tab [STEPS];
  logic [PW-1:0]          pix_w;
  logic                   in_win1;
  logic                   in_win2;
  logic [SW-1:0]          step1;
  logic [SW-1:0]          step2;
  logic [SW-1:0]          fade_step;
  logic [KW-1:0]          fade_k;
  logic [tzgp_pkg::COLOR_W-1:0] fade_a;
  logic [tzgp_pkg::COLOR_W-1:0] fade_b;
  logic [tzgp_pkg::COLOR_W-1:0] fade_col;
  logic [tzgp_pkg::COLOR_W-1:0] col_next;

  // One channel of a fade: a + floor(d*i/L) rising, a - ceil(d*i/L) falling
  function automatic logic [tzgp_pkg::CHAN_W-1:0] fade_chan(
    input logic [tzgp_pkg::CHAN_W-1:0] a,
    input logic [tzgp_pkg::CHAN_W-1:0] b,
    input logic [KW-1:0]               k
  );
    logic                        up;
    logic [tzgp_pkg::CHAN_W-1:0] d;
    logic [PRW-1:0]              p;
    logic [tzgp_pkg::CHAN_W-1:0] q;
    up = (a < b);
    d  = up ? (b - a) : (a - b);
    p  = PRW'(d) * PRW'(k) + (up ? PRW'(0) : PRW'(CEIL_ADD));
    q  = p[SH +: tzgp_pkg::CHAN_W];
    return up ? (a + q) : (a - q);
  endfunction

  // Write configuration registers; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      first_color  <= '0;
      second_color <= '0;
      third_color  <= '0;
    end else if (write_enable) begin
      case (write_index)
        tzgp_pkg::REG_FIRST_COLOR:  first_color  <= write_data;
        tzgp_pkg::REG_SECOND_COLOR: second_color <= write_data;
        tzgp_pkg::REG_THIRD_COLOR:  third_color  <= write_data;
        default: ;
      endcase
    end
  end

  // Handshake: the result register advances when empty or taken
  assign advance  = !out_valid || !out_stall;
  assign in_stall = s1_valid && !advance;
  assign accept   = in_valid && !in_stall;

  // Capture the pixel index
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      pix_r <= pixel_index;
    end
  end

  assign pix_w = PW'(pix_r);

  // Match the index against each step position of both windows
  for (genvar i = 0; i < FADE_LENGTH; i++) begin : g_win
    localparam int POS1 = (BASE1 + i) % PIXEL_COUNT;
    localparam int POS2 = (BASE2 + i) % PIXEL_COUNT;
    assign hit1[i] = (pix_w == PW'(POS1));
    assign hit2[i] = (pix_w == PW'(POS2));
  end

  // Scaled reciprocal for each step: i * MAGIC
  for (genvar i = 0; i < STEPS; i++) begin : g_ktab
    localparam int KI = (i < FADE_LENGTH) ? i * MAGIC : 0;
    assign k_tab[i] = KW'(KI);
  end

  // Take the highest matching step of each window
  always_comb begin
    step1 = '0;
    step2 = '0;
    for (int i = 0; i < FADE_LENGTH; i++) begin
      if (hit1[i]) begin
        step1 = SW'(i);
      end
      if (hit2[i]) begin
        step2 = SW'(i);
      end
    end
  end

  assign in_win1 = |hit1;
  assign in_win2 = |hit2;

  // The second window wins where both cover the pixel
  assign fade_a    = in_win2 ? second_color : first_color;
  assign fade_b    = in_win2 ? third_color  : second_color;
  assign fade_step = in_win2 ? step2 : step1;
  assign fade_k    = k_tab[fade_step];

  assign fade_col = {
    fade_chan(fade_a[23:16], fade_b[23:16], fade_k),
    fade_chan(fade_a[15:8],  fade_b[15:8],  fade_k),
    fade_chan(fade_a[7:0],   fade_b[7:0],   fade_k)
  };

  // Pick zone color, fade or black
  always_comb begin
    if (pix_w >= PW'(PIXEL_COUNT)) begin
      col_next = '0;
    end else if (in_win1 || in_win2) begin
      col_next = fade_col;
    end else if (pix_w < PW'(M1)) begin
      col_next = first_color;
    end else if (pix_w < PW'(M2)) begin
      col_next = second_color;
    end else begin
      col_next = third_color;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
    if (advance && s1_valid) begin
      red   <= col_next[23:16];
      green <= col_next[15:8];
      blue  <= col_next[7:0];
    end
  end

  // Stall only reaches the input side when the input register is full
  a_stall_needs_word: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // An accepted word is held in the input register next cycle
  a_accept_holds: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> s1_valid)
    else $error("accepted word lost");

  // A new result only comes from a held input word
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(s1_valid))
    else $error("result without input word");

  // An index past the strip yields black
  a_black_beyond: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && advance && (pix_w >= PW'(PIXEL_COUNT)))
      |=> (red == '0 && green == '0 && blue == '0))
    else $error("index past strip not black");

endmodule
